[rtl/rgb_box_blur_3x3_unit_macros.svh]
// Assertion macros for the RGB 3x3 box blur unit
`ifndef RGB_BOX_BLUR_3X3_UNIT_MACROS_SVH
`define RGB_BOX_BLUR_3X3_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define BLUR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define BLUR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rgbblur_pkg.sv]
// Shared constants and types for the RGB 3x3 box blur unit
`timescale 1ns / 1ps

package rgbblur_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 8'd0,
    REG_FRAME_HEIGHT = 8'd1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [CFG_W-1:0] MIN_DIM      = 12'd3;

  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int PIX_W     = CH_W * NUM_CH;
  localparam int COL_OUT_W = 11;
  localparam int ROW_W     = 12;
  localparam int RSUM_W    = 10;
  localparam int SUM_W     = 12;
  localparam int OUT_W     = 48;

  // floor(s / 9) = (s * 3641) >> 15 for every s up to 9 * 255
  localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
  localparam int               DIV9_SHIFT = 15;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic                 done;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
  } res_meta_t;

endpackage

[rtl/rgb_box_blur_3x3_unit.sv]
// RGB 3x3 box blur over a raster pixel stream.
// Input channel s_axis: one pixel per transaction in raster order; tdata holds
// red, green, blue, tuser marks the first pixel of a frame and resets the position.
// Output channel m_axis: one transaction per interior pixel, emitted when the
// pixel below and to the right of it arrives; border rows and columns give none.
// tdata carries the three channel averages (floor of the 3x3 sum / 9), the
// column and row of the centre; tlast flags the last interior pixel of a frame.
// Configuration channel cfg: index 0 sets frame width, index 1 frame height;
// write only while the block is idle.
// Throughput: one pixel per cycle unless a held result stalls the input. The line
// stores share one dual-port memory with a registered read; a write-back to the
// column just read is forwarded. Pipeline: a pixel that completes a window passes
// memory read at accept, row sums, total, multiply by 1/9, then the output register.
// Reset: position returns to row 0 column 0, frame size to 640 x 480, the pipeline
// empties. Line stores are not cleared and need no clearing pass.
// Stall: a held result waits in the output register while the stages behind it
// fill; input is refused once they are full and the waiting pixel owes a result.
`timescale 1ns / 1ps
`include "rgb_box_blur_3x3_unit_macros.svh"

module rgb_box_blur_3x3_unit #(
  parameter int MAX_WIDTH = rgbblur_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] pix_r, [15:8] pix_g, [23:16] pix_b
  input  logic [rgbblur_pkg::PIX_W-1:0]        s_axis_tdata,
  // [0] frame_start
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] out_r, [15:8] out_g, [23:16] out_b, [34:24] out_col, [46:35] out_row, [47] zero
  output logic [rgbblur_pkg::OUT_W-1:0]        m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rgbblur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbblur_pkg::CFG_W-1:0]        cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WCW = (CW + 1 > rgbblur_pkg::CFG_W) ? CW + 1 : rgbblur_pkg::CFG_W;
  localparam int RW  = rgbblur_pkg::ROW_W;
  localparam int CHW = rgbblur_pkg::CH_W;
  localparam int NCH = rgbblur_pkg::NUM_CH;
  localparam int PW  = rgbblur_pkg::PIX_W;
  localparam int RSW = rgbblur_pkg::RSUM_W;
  localparam int SW  = rgbblur_pkg::SUM_W;

  // configuration
  logic [rgbblur_pkg::CFG_W-1:0] frame_width;
  logic [rgbblur_pkg::CFG_W-1:0] frame_height;
  logic [WCW-1:0]                w_use;
  logic [RW-1:0]                 h_use;

  // position
  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [CW-1:0] col_base, col_cur;
  logic [RW-1:0] row_base, row_cur;
  logic [RW:0]   row_inc, row_p1;
  logic [WCW-1:0] col_p1;
  logic          emit_cur;
  rgbblur_pkg::res_meta_t meta_cur;

  // handshake
  logic s_acc, cfg_acc;
  logic ready2, ready3, ready4;
  logic s1_go, s2_go, s3_go;

  // line store memory: {upper, middle}
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_q;
  logic            byp;
  logic [2*PW-1:0] byp_data;
  logic [2*PW-1:0] wr_data;

  // stage 1
  logic                   s1_valid;
  logic                   s1_emit;
  logic [CW-1:0]          s1_col;
  rgbblur_pkg::pix_t      s1_pix;
  rgbblur_pkg::res_meta_t s1_meta;
  rgbblur_pkg::pix_t      up_eff, mid_eff;
  rgbblur_pkg::pix_t      win [9];
  rgbblur_pkg::pix_t      win_next [9];
  logic [RSW-1:0]         rsum_next [3][NCH];

  // stage 2
  logic                   s2_valid;
  logic [RSW-1:0]         s2_rsum [3][NCH];
  rgbblur_pkg::res_meta_t s2_meta;

  // stage 3
  logic                   s3_valid;
  logic [SW-1:0]          s3_sum [NCH];
  rgbblur_pkg::res_meta_t s3_meta;
  logic [2*SW-1:0]        prod [NCH];

  // output register
  logic                   o_valid;
  logic [CHW-1:0]         o_q [NCH];
  rgbblur_pkg::res_meta_t o_meta;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    if (WCW'(frame_width) < WCW'(rgbblur_pkg::MIN_DIM)) begin
      w_use = WCW'(rgbblur_pkg::MIN_DIM);
    end else if (WCW'(frame_width) > WCW'(MAX_WIDTH)) begin
      w_use = WCW'(MAX_WIDTH);
    end else begin
      w_use = WCW'(frame_width);
    end
    h_use = (frame_height < rgbblur_pkg::MIN_DIM) ? rgbblur_pkg::MIN_DIM : frame_height;
  end

  // position of the arriving pixel and of the next one
  always_comb begin
    col_base = s_axis_tuser ? '0 : column_count;
    row_base = s_axis_tuser ? '0 : row_count;
    if (WCW'(col_base) >= w_use) begin
      col_cur = '0;
      row_inc = {1'b0, row_base} + (RW+1)'(1);
    end else begin
      col_cur = col_base;
      row_inc = {1'b0, row_base};
    end
    row_cur = (row_inc >= {1'b0, h_use}) ? '0 : row_inc[RW-1:0];
    col_p1  = WCW'(col_cur) + WCW'(1);
    row_p1  = {1'b0, row_cur} + (RW+1)'(1);
    if (col_p1 >= w_use) begin
      column_count_next = '0;
      row_count_next    = (row_p1 >= {1'b0, h_use}) ? '0 : row_p1[RW-1:0];
    end else begin
      column_count_next = col_p1[CW-1:0];
      row_count_next    = row_cur;
    end
    emit_cur      = (WCW'(col_cur) > WCW'(1)) && (row_cur > RW'(1));
    meta_cur.col  = rgbblur_pkg::COL_OUT_W'(WCW'(col_cur) - WCW'(1));
    meta_cur.row  = row_cur - RW'(1);
    meta_cur.done = (col_p1 == w_use) && (row_p1 == {1'b0, h_use});
  end

  // stage handshakes
  always_comb begin
    ready4        = !o_valid || m_axis_tready;
    s3_go         = s3_valid && ready4;
    ready3        = !s3_valid || ready4;
    s2_go         = s2_valid && ready3;
    ready2        = !s2_valid || ready3;
    s1_go         = s1_valid && (!s1_emit || ready2);
    s_axis_tready = !s1_valid || s1_go;
    s_acc         = s_axis_tvalid && s_axis_tready;
  end

  // window update and row sums
  always_comb begin
    up_eff  = byp ? byp_data[2*PW-1:PW] : rd_q[2*PW-1:PW];
    mid_eff = byp ? byp_data[PW-1:0]    : rd_q[PW-1:0];
    wr_data = {mid_eff, s1_pix};
    for (int r = 0; r < 3; r++) begin
      win_next[3*r]     = win[3*r+1];
      win_next[3*r + 1] = win[3*r+2];
    end
    win_next[2] = up_eff;
    win_next[5] = mid_eff;
    win_next[8] = s1_pix;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < NCH; c++) begin
        rsum_next[r][c] = RSW'(win_next[3*r][CHW*c +: CHW])
                        + RSW'(win_next[3*r+1][CHW*c +: CHW])
                        + RSW'(win_next[3*r+2][CHW*c +: CHW]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod[c] = (2*SW)'(s3_sum[c]) * (2*SW)'(rgbblur_pkg::DIV9_MUL);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rgbblur_pkg::WIDTH_RESET;
      frame_height <= rgbblur_pkg::HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      o_valid      <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          rgbblur_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          rgbblur_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (s_acc) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        s1_valid     <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        for (int i = 0; i < 9; i++) begin
          win[i] <= win_next[i];
        end
      end
      if (s1_go && s1_emit) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
      if (s2_go) begin
        s3_valid <= 1'b1;
      end else if (s3_go) begin
        s3_valid <= 1'b0;
      end
      if (s3_go) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // line store memory: read at accept, write back when stage 1 retires
  always_ff @(posedge clk) begin
    if (s_acc) begin
      rd_q     <= line_mem[col_cur];
      byp      <= s1_go && (s1_col == col_cur);
      byp_data <= wr_data;
    end
    if (s1_go) begin
      line_mem[s1_col] <= wr_data;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_emit <= emit_cur;
      s1_col  <= col_cur;
      s1_pix  <= s_axis_tdata;
      s1_meta <= meta_cur;
    end
    if (s1_go && s1_emit) begin
      s2_rsum <= rsum_next;
      s2_meta <= s1_meta;
    end
    if (s2_go) begin
      for (int c = 0; c < NCH; c++) begin
        s3_sum[c] <= SW'(s2_rsum[0][c]) + SW'(s2_rsum[1][c]) + SW'(s2_rsum[2][c]);
      end
      s3_meta <= s2_meta;
    end
    if (s3_go) begin
      for (int c = 0; c < NCH; c++) begin
        o_q[c] <= prod[c][rgbblur_pkg::DIV9_SHIFT +: CHW];
      end
      o_meta <= s3_meta;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tlast  = o_meta.done;
  assign m_axis_tdata  = {1'b0, o_meta.row, o_meta.col, o_q[2], o_q[1], o_q[0]};

  `BLUR_ASSERT_SAME(a_empty_ready,
    !s1_valid && !s2_valid && !s3_valid && !o_valid,
    s_axis_tready,
    "input refused with an empty pipeline")
  `BLUR_ASSERT_NEXT(a_col_in_range,
    s_acc && !cfg_acc,
    WCW'(column_count) < w_use,
    "column position beyond frame width")
  `BLUR_ASSERT_SAME(a_interior_only,
    o_valid,
    (o_meta.col != '0) && (o_meta.row != '0),
    "result offered for a border pixel")

endmodule
